// ----- rtl/core/sliding_window_median_assert.svh -----
// assertion macros for the sliding window median block
// expects a clock named clk and an active-high reset named rst in the using scope
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// overlapping implication, off during reset
`define SWM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swm: property violated");

// next-cycle implication, off during reset
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swm: property violated");

// next-cycle implication that also holds through reset
`define SWM_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("swm: property violated");

`endif

// ----- rtl/core/swm_pkg.sv -----
// shared types and constants of the sliding window median block
// no dependencies
`default_nettype none

package swm_pkg;

  // width and reset value of the window size register
  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 16;

  // per-cycle command broadcast to every cell of the sorted chain
  typedef struct packed {
    logic clear;   // drop all held samples
    logic del_en;  // remove the sample of the current slot
    logic ins_en;  // insert the new sample in order
    logic pick;    // capture the middle pair
  } swm_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/swm_cell.sv -----
// one cell of the sorted chain: a sample, its window slot and a valid bit
// depends on swm_pkg
`default_nettype none

module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int POS_W        = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire swm_cmd_t                cmd,
  input  wire logic [POS_W-1:0]        wp,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  // neighbour below (smaller values)
  input  wire logic                    low_valid,
  input  wire logic [POS_W-1:0]        low_tag,
  input  wire logic [SAMPLE_WIDTH-1:0] low_value,
  input  wire logic                    low_gt,
  input  wire logic                    low_hole,
  // neighbour above (larger values)
  input  wire logic                    up_valid,
  input  wire logic [POS_W-1:0]        up_tag,
  input  wire logic [SAMPLE_WIDTH-1:0] up_value,
  // own contents and chain outputs
  output logic                         valid,
  output logic [POS_W-1:0]             tag,
  output logic [SAMPLE_WIDTH-1:0]      value,
  output logic                         gt,
  output logic                         hole
);

  // empty cells sort above everything
  always_comb begin
    gt   = !valid || ($signed(value) > $signed(sample));
    hole = low_hole || (valid && (tag == wp));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.del_en && hole) begin
      // close the gap: pull the upper neighbour down
      valid <= up_valid;
      tag   <= up_tag;
      value <= up_value;
    end else if (cmd.ins_en) begin
      if (low_gt) begin
        // make room: take the lower neighbour
        valid <= low_valid;
        tag   <= low_tag;
        value <= low_value;
      end else if (gt) begin
        valid <= 1'b1;
        tag   <= wp;
        value <= sample;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/swm_chain.sv -----
// sorted chain of cells and the registered pick of its middle pair
// depends on swm_pkg and swm_cell
`default_nettype none

module swm_chain import swm_pkg::*; #(
  parameter int WINDOW_MAX   = 16,
  parameter int SAMPLE_WIDTH = 16,
  parameter int POS_W        = 4,
  parameter int CNT_W        = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire swm_cmd_t                cmd,
  input  wire logic [POS_W-1:0]        wp,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  input  wire logic [CNT_W-1:0]        fill,
  output logic [SAMPLE_WIDTH-1:0]      lo_value,
  output logic [SAMPLE_WIDTH-1:0]      hi_value
);

  logic                    c_valid [WINDOW_MAX];
  logic [POS_W-1:0]        c_tag   [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] c_value [WINDOW_MAX];
  logic                    c_gt    [WINDOW_MAX];
  logic                    c_hole  [WINDOW_MAX];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                    l_valid;
    logic [POS_W-1:0]        l_tag;
    logic [SAMPLE_WIDTH-1:0] l_value;
    logic                    l_gt;
    logic                    l_hole;
    logic                    u_valid;
    logic [POS_W-1:0]        u_tag;
    logic [SAMPLE_WIDTH-1:0] u_value;

    if (i == 0) begin : g_bottom
      assign l_valid = 1'b0;
      assign l_tag   = '0;
      assign l_value = '0;
      assign l_gt    = 1'b0;
      assign l_hole  = 1'b0;
    end else begin : g_low
      assign l_valid = c_valid[i-1];
      assign l_tag   = c_tag[i-1];
      assign l_value = c_value[i-1];
      assign l_gt    = c_gt[i-1];
      assign l_hole  = c_hole[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_top
      assign u_valid = 1'b0;
      assign u_tag   = '0;
      assign u_value = '0;
    end else begin : g_up
      assign u_valid = c_valid[i+1];
      assign u_tag   = c_tag[i+1];
      assign u_value = c_value[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .POS_W        (POS_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .wp        (wp),
      .sample    (sample),
      .low_valid (l_valid),
      .low_tag   (l_tag),
      .low_value (l_value),
      .low_gt    (l_gt),
      .low_hole  (l_hole),
      .up_valid  (u_valid),
      .up_tag    (u_tag),
      .up_value  (u_value),
      .valid     (c_valid[i]),
      .tag       (c_tag[i]),
      .value     (c_value[i]),
      .gt        (c_gt[i]),
      .hole      (c_hole[i])
    );
  end

  // middle pair positions; equal for an odd count
  logic [CNT_W-1:0]        lo_idx;
  logic [CNT_W-1:0]        hi_idx;
  logic [SAMPLE_WIDTH-1:0] lo_sel;
  logic [SAMPLE_WIDTH-1:0] hi_sel;

  always_comb begin
    lo_idx = (fill - CNT_W'(1)) >> 1;
    hi_idx = fill >> 1;
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (lo_idx == CNT_W'(i)) lo_sel = lo_sel | c_value[i];
      if (hi_idx == CNT_W'(i)) hi_sel = hi_sel | c_value[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      lo_value <= lo_sel;
      hi_value <= hi_sel;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sliding_window_median.sv -----
// sliding window median filter, top level: control sequencer and output register
// depends on swm_pkg and swm_chain (which holds the swm_cell row)
// sample channel: sample_valid / sample_ready, one signed sample per transfer
// median channel: median_valid / median_ready, one median per sample, in order
// window_size / window_size_we: length of the window (0 reads as 1, values
//   above WINDOW_MAX read as WINDOW_MAX); a write empties the window and restarts
//   the slot position; it must be made only while the block is idle (unchecked)
// the held samples live in a row of cells kept in ascending order; each
//   sample first drops the one of its slot once the window is full, is then
//   inserted in order, the middle pair is captured, and it is averaged into
//   the output register
// median_valid is registered and rises as the averaging step completes
// a new sample is taken only once the sequencer is back in idle after the
//   three steps of the cell row and the averaging step
// stalls: a pending median stays in the output register while a new sample
//   is taken and processed; the averaging step waits while that register is full
// reset empties the window, sets the length to 16 (capped at WINDOW_MAX)
//   and drops any pending median
`default_nettype none

module sliding_window_median import swm_pkg::*; #(
  parameter int WINDOW_MAX   = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // window length register
  input  wire logic                    window_size_we,
  input  wire logic [CFG_W-1:0]        window_size,
  // sample channel
  input  wire logic                    sample_valid,
  output logic                         sample_ready,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  // median channel
  output logic                         median_valid,
  input  wire logic                    median_ready,
  output logic [SAMPLE_WIDTH-1:0]      median_value
);

  localparam int POS_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RESET_SIZE = (CFG_RESET > WINDOW_MAX) ? WINDOW_MAX : CFG_RESET;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEL  = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic [SAMPLE_WIDTH-1:0] sample_hold;
  logic [CNT_W-1:0]        size;       // effective window length
  logic [CNT_W-1:0]        size_next;
  logic [POS_W-1:0]        wp;         // slot of the next sample
  logic [POS_W-1:0]        wp_next;
  logic [CNT_W-1:0]        fill;       // samples currently held
  logic                    full;
  swm_cmd_t                cmd;
  logic [SAMPLE_WIDTH-1:0] lo_value;
  logic [SAMPLE_WIDTH-1:0] hi_value;
  logic [SAMPLE_WIDTH:0]   pair_sum;
  logic [SAMPLE_WIDTH:0]   pair_adj;
  logic                    out_free;
  logic [CMP_W-1:0]        size_raw;

  assign sample_ready = (state == ST_IDLE);
  assign full         = (fill == size);
  assign out_free     = !median_valid || median_ready;

  // clamp the written length into 1..WINDOW_MAX
  always_comb begin
    size_raw = CMP_W'(window_size);
    if (size_raw == '0) begin
      size_next = CNT_W'(1);
    end else if (size_raw > CMP_W'(WINDOW_MAX)) begin
      size_next = CNT_W'(WINDOW_MAX);
    end else begin
      size_next = CNT_W'(size_raw);
    end
  end

  // slot position wraps at the window length
  always_comb begin
    if ((CNT_W'(wp) + CNT_W'(1)) == size) begin
      wp_next = '0;
    end else begin
      wp_next = wp + POS_W'(1);
    end
  end

  // command to the cell row for the current step
  always_comb begin
    cmd.clear  = window_size_we;
    cmd.del_en = (state == ST_DEL) && full;
    cmd.ins_en = (state == ST_INS);
    cmd.pick   = (state == ST_PICK);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid) state_next = ST_DEL;
      end
      ST_DEL:  state_next = ST_INS;
      ST_INS:  state_next = ST_PICK;
      ST_PICK: state_next = ST_ADD;
      ST_ADD: begin
        // hold while an earlier median is still waiting
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      sample_hold <= sample;
    end
  end

  // window length, slot position and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= CNT_W'(RESET_SIZE);
      wp   <= '0;
      fill <= '0;
    end else if (window_size_we) begin
      size <= size_next;
      wp   <= '0;
      fill <= '0;
    end else if (state == ST_INS) begin
      wp <= wp_next;
      if (!full) fill <= fill + CNT_W'(1);
    end
  end

  swm_chain #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .POS_W        (POS_W),
    .CNT_W        (CNT_W)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .wp       (wp),
    .sample   (sample_hold),
    .fill     (fill),
    .lo_value (lo_value),
    .hi_value (hi_value)
  );

  // mean of the middle pair, rounded toward zero; an odd count gives lo == hi
  always_comb begin
    pair_sum = {lo_value[SAMPLE_WIDTH-1], lo_value} + {hi_value[SAMPLE_WIDTH-1], hi_value};
    pair_adj = pair_sum + (SAMPLE_WIDTH + 1)'(pair_sum[SAMPLE_WIDTH]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if ((state == ST_ADD) && out_free) begin
      median_valid <= 1'b1;
    end else if (median_ready) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_ADD) && out_free) begin
      median_value <= pair_adj[SAMPLE_WIDTH:1];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/swm_checker.sv -----
// port-level checks of the sliding window median block, bound to its top level
// depends on sliding_window_median_assert.svh
`default_nettype none
`include "sliding_window_median_assert.svh"

module swm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic sample_valid,
  input wire logic sample_ready,
  input wire logic median_valid,
  input wire logic median_ready
);

  // a stalled median stays offered
  `SWM_ASSERT_NEXT(a_median_held, median_valid && !median_ready, median_valid)

  // the four processing steps keep the sample side closed
  `SWM_ASSERT_NEXT(a_busy_after_transfer, sample_valid && sample_ready,
    !sample_ready ##1 !sample_ready ##1 !sample_ready ##1 !sample_ready)

  // a new median only appears as the sequencer returns to idle
  `SWM_ASSERT_IMPLY(a_median_at_idle, $rose(median_valid), sample_ready)

  // reset drops any pending median
  `SWM_ASSERT_ALWAYS(a_reset_empty, rst, !median_valid)

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

`default_nettype wire
